// File: rtl/fbfl_pkg.sv
package fbfl_pkg;

    localparam int MAX_BLOCKS_DEFAULT   = 1024;
    localparam int WORD_BYTES_DEFAULT   = 8;
    localparam int HEADER_BYTES_DEFAULT = 8;

    localparam int NUM_BLOCKS_W    = 11;
    localparam int BLOCK_BYTES_W   = 13;
    localparam int CFG_DATA_W      = 13;
    localparam int INDEX_W         = 10;
    localparam int OFFSET_W        = 22;
    localparam int COUNT_W         = 11;

    localparam int NUM_BLOCKS_RESET  = 1024;
    localparam int BLOCK_BYTES_RESET = 8;
    localparam int BLOCK_BYTES_CAP   = 4096;
    localparam int COUNT_MAX         = 2047;

    localparam logic CFG_NUM_BLOCKS  = 1'b0;
    localparam logic CFG_BLOCK_BYTES = 1'b1;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INIT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   free_index;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [INDEX_W-1:0]   block_index;
        logic [OFFSET_W-1:0]  block_offset;
        logic [COUNT_W-1:0]   free_count;
    } rsp_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

// File: rtl/fbfl_ctrl.sv
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/fbfl_datapath.sv
module fbfl_datapath
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEFAULT,
    parameter int WORD_BYTES   = WORD_BYTES_DEFAULT,
    parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  req_t                  req,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output rsp_t                  rsp
);

    localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PW    = $clog2(MAX_BLOCKS + 1);
    localparam int RESET_POOL = (NUM_BLOCKS_RESET > MAX_BLOCKS) ? MAX_BLOCKS : NUM_BLOCKS_RESET;

    // ceil(s/W) via reciprocal, exact for 14-bit dividends with W <= 64
    localparam int    RND_T_W = 14;
    localparam int    RND_SH  = RND_T_W + 7;
    localparam int    RND_P_W = RND_T_W + RND_SH + 1;
    localparam longint RECIP  = ((64'd1 << RND_SH) + WORD_BYTES - 1) / WORD_BYTES;

    logic [NUM_BLOCKS_W-1:0]  num_blocks_reg;
    logic [BLOCK_BYTES_W-1:0] block_bytes_reg;
    logic [BLOCK_BYTES_W-1:0] rounded_reg;
    logic [BLOCK_BYTES_W-1:0] rounded_next;

    kind_t                    kind_reg;
    logic [INDEX_W-1:0]       idx_reg;

    logic [PW-1:0]            head_reg;
    logic [PW-1:0]            head_next;
    logic [PW-1:0]            fresh_reg;
    logic [PW-1:0]            fresh_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;

    logic [PW-1:0]            link_mem [0:MAX_BLOCKS-1];
    logic [PW-1:0]            link_rd_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;

    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     done_reg;

    logic [PW-1:0]            pool;
    logic [31:0]              idx_wide;
    logic [IDX_W-1:0]         blk;
    logic [31:0]              offset_full;

    logic [BLOCK_BYTES_W-1:0] size_clamped;
    logic [RND_T_W-1:0]       size_bias;
    logic [RND_P_W-1:0]       rnd_prod;
    logic [RND_T_W-1:0]       rnd_quot;
    logic [RND_T_W+7:0]       rnd_size;

    always_comb
    begin
        if ({21'd0, num_blocks_reg} >= 32'(MAX_BLOCKS))
        begin
            pool = PW'(MAX_BLOCKS);
        end
        else
        begin
            pool = PW'(num_blocks_reg);
        end
    end

    always_comb
    begin
        if ({19'd0, block_bytes_reg} > 32'(BLOCK_BYTES_CAP))
        begin
            size_clamped = BLOCK_BYTES_W'(BLOCK_BYTES_CAP);
        end
        else if ({19'd0, block_bytes_reg} < 32'(WORD_BYTES))
        begin
            size_clamped = BLOCK_BYTES_W'(WORD_BYTES);
        end
        else
        begin
            size_clamped = block_bytes_reg;
        end
        size_bias    = RND_T_W'(size_clamped) + RND_T_W'(WORD_BYTES - 1);
        rnd_prod     = RND_P_W'(size_bias) * RND_P_W'(RECIP);
        rnd_quot     = RND_T_W'(rnd_prod >> RND_SH);
        rnd_size     = (RND_T_W+8)'(rnd_quot) * (RND_T_W+8)'(WORD_BYTES);
        rounded_next = rnd_size[BLOCK_BYTES_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        rounded_reg <= rounded_next;
        if (cmd.capture)
        begin
            kind_reg <= req.kind;
            idx_reg  <= req.free_index;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg  <= NUM_BLOCKS_W'(NUM_BLOCKS_RESET);
            block_bytes_reg <= BLOCK_BYTES_W'(BLOCK_BYTES_RESET);
            head_reg        <= PW'(MAX_BLOCKS);
            fresh_reg       <= '0;
            count_reg       <= COUNT_W'(RESET_POOL);
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_BLOCKS:  num_blocks_reg  <= cfg_data[NUM_BLOCKS_W-1:0];
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data[BLOCK_BYTES_W-1:0];
                    default:         num_blocks_reg  <= num_blocks_reg;
                endcase
            end
            if (cmd.execute)
            begin
                head_reg  <= head_next;
                fresh_reg <= fresh_next;
                count_reg <= count_next;
            end
            done_reg <= cmd.execute;
        end
    end

    // link read follows the head every cycle; data is ready in the execute cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= head_reg;
        end
        link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        idx_wide    = 32'(idx_reg);
        mem_waddr   = idx_wide[IDX_W-1:0];
        mem_we      = 1'b0;
        head_next   = head_reg;
        fresh_next  = fresh_reg;
        count_next  = count_reg;
        blk         = '0;
        offset_full = '0;

        rsp_next.ok           = 1'b0;
        rsp_next.block_index  = '0;
        rsp_next.block_offset = '0;

        unique case (kind_reg)
            KIND_ALLOC:
            begin
                if (head_reg < PW'(MAX_BLOCKS))
                begin
                    blk         = head_reg[IDX_W-1:0];
                    head_next   = link_rd_reg;
                    rsp_next.ok = 1'b1;
                end
                else if (fresh_reg < pool)
                begin
                    blk         = fresh_reg[IDX_W-1:0];
                    fresh_next  = fresh_reg + PW'(1);
                    rsp_next.ok = 1'b1;
                end
                if (rsp_next.ok)
                begin
                    offset_full = 32'(HEADER_BYTES) + 32'(blk) * 32'(rounded_reg);
                    rsp_next.block_index  = INDEX_W'(blk);
                    rsp_next.block_offset = offset_full[OFFSET_W-1:0];
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
            end
            KIND_FREE:
            begin
                if (idx_wide < 32'(pool))
                begin
                    mem_we      = cmd.execute;
                    head_next   = PW'(idx_wide);
                    rsp_next.ok = 1'b1;
                    if (count_reg != COUNT_W'(COUNT_MAX))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            KIND_INIT:
            begin
                head_next   = PW'(MAX_BLOCKS);
                fresh_next  = '0;
                count_next  = COUNT_W'(pool);
                rsp_next.ok = 1'b1;
            end
            default:
            begin
                rsp_next.ok = 1'b0;
            end
        endcase

        rsp_next.free_count = count_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: rtl/fixed_block_free_list_allocator_core.sv
// Fixed-size block allocator with a LIFO free list. Issue an operation by
// raising start with req while busy is low; the transfer takes place at that
// clock edge. The operation is first captured while the link memory is read at
// the list head, then executed to update head, fresh mark and counter. The
// result is registered on rsp at the execute step, with done high for exactly
// one cycle, and cannot be stalled; a new operation may be issued in that same
// cycle. Config writes (cfg_we) take effect at once and must only be issued
// while no operation is in flight.
module fixed_block_free_list_allocator_core
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEFAULT,
    parameter int WORD_BYTES   = WORD_BYTES_DEFAULT,
    parameter int HEADER_BYTES = HEADER_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;

    fbfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    fbfl_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .WORD_BYTES   (WORD_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .rsp       (rsp)
    );

endmodule
